// ===== design/dpft_pkg.sv =====
// ---------------------------------------------------------------------------
// dpft_pkg
// Shared types and constants for the demand paging FIFO translator.
// ---------------------------------------------------------------------------
package dpft_pkg;

    // fixed field widths
    localparam int VA_W      = 22;
    localparam int PA_W      = 16;
    localparam int EV_PAGE_W = 10;

    // parameter defaults
    localparam int PAGE_OFFSET_BITS_DEF = 12;
    localparam int VIRTUAL_PAGES_DEF    = 1024;
    localparam int FRAMES_DEF           = 16;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // input item
    typedef struct packed {
        logic            cmd;
        logic [VA_W-1:0] virt_addr;
    } t_req;

    // result item
    typedef struct packed {
        logic [PA_W-1:0]      phys_addr;
        logic                 page_fault;
        logic                 evict_valid;
        logic [EV_PAGE_W-1:0] evict_page;
        logic                 evict_writeback;
    } t_rsp;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_LOOK = 2'b01,
        S_EXEC = 2'b10
    } t_back_state;

endpackage

// ===== design/demand_paging_fifo_translator_unit.sv =====
// ---------------------------------------------------------------------------
// demand_paging_fifo_translator_unit
// Virtual to physical address translator with FIFO page replacement.
//
// Usage:
//   An access item (i_req: cmd, virt_addr) is taken at a rising edge with
//   start high and busy low. busy is high while the two-entry input queue
//   is full.
//   Each item gives exactly one result on o_rsp, marked by o_rsp_valid for
//   one cycle. The receiver cannot stall; results leave at once.
//   Each result passes the input queue, the sequencer's look-up and execute
//   states and the result register; queued items ahead of it delay it.
//   The back end sequencer matches the page against the per-frame owner
//   table in its look-up state and updates owner, in-use, dirty and the
//   FIFO pointer in the execute state that follows, before the next pop.
//   On a fault the frame under the FIFO pointer is taken; an evicted page
//   and its write-back need are reported for an external copy engine.
//   Reset (i_rst_n low, synchronous) empties the queue, marks every frame
//   free and clean and returns the FIFO pointer to frame zero.
// ---------------------------------------------------------------------------
module demand_paging_fifo_translator_unit
    import dpft_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
    parameter int VIRTUAL_PAGES    = VIRTUAL_PAGES_DEF,
    parameter int FRAMES           = FRAMES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    localparam int PAGE_BITS = $clog2(VIRTUAL_PAGES);

    logic                        full;
    logic                        push;
    logic                        q_valid;
    logic                        q_pop;
    logic                        q_cmd;
    logic [PAGE_BITS-1:0]        q_page;
    logic [PAGE_OFFSET_BITS-1:0] q_off;

    assign busy = full;
    assign push = start && !full;

    // accept and classify
    dpft_front #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .VIRTUAL_PAGES    (VIRTUAL_PAGES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_req     (i_req),
        .o_full    (full),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_cmd   (q_cmd),
        .o_q_page  (q_page),
        .o_q_off   (q_off)
    );

    // translate and replace
    dpft_back #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .VIRTUAL_PAGES    (VIRTUAL_PAGES),
        .FRAMES           (FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_cmd     (q_cmd),
        .i_q_page    (q_page),
        .i_q_off     (q_off),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== design/dpft_front.sv =====
// ---------------------------------------------------------------------------
// dpft_front
// Accepts access items, splits the address into page and offset, and holds
// them in a short queue for the back end.
// ---------------------------------------------------------------------------
module dpft_front
    import dpft_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
    parameter int VIRTUAL_PAGES    = VIRTUAL_PAGES_DEF,
    localparam int PAGE_BITS       = $clog2(VIRTUAL_PAGES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  t_req                        i_req,
    output logic                        o_full,
    output logic                        o_q_valid,
    input  logic                        i_q_pop,
    output logic                        o_q_cmd,
    output logic [PAGE_BITS-1:0]        o_q_page,
    output logic [PAGE_OFFSET_BITS-1:0] o_q_off
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                        r_q_cmd  [QUEUE_DEPTH];
    logic [PAGE_BITS-1:0]        r_q_page [QUEUE_DEPTH];
    logic [PAGE_OFFSET_BITS-1:0] r_q_off  [QUEUE_DEPTH];
    logic [QPTR_W-1:0]           r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]           r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]           r_count, n_count;

    logic [VA_W-1:0]             va_shift;
    logic [PAGE_BITS-1:0]        page;
    logic [PAGE_OFFSET_BITS-1:0] offset;

    // classify: page number wraps modulo the page count
    always_comb begin
        va_shift = i_req.virt_addr >> PAGE_OFFSET_BITS;
        page     = PAGE_BITS'(va_shift);
        offset   = i_req.virt_addr[PAGE_OFFSET_BITS-1:0];
    end

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q_cmd[r_wr_ptr]  <= i_req.cmd;
            r_q_page[r_wr_ptr] <= page;
            r_q_off[r_wr_ptr]  <= offset;
        end
    end

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_q_cmd[r_rd_ptr];
    assign o_q_page  = r_q_page[r_rd_ptr];
    assign o_q_off   = r_q_off[r_rd_ptr];

    // queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a pop with no push leaves one item fewer
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

// ===== design/dpft_back.sv =====
// ---------------------------------------------------------------------------
// dpft_back
// Translates queued accesses: per-frame owner lookup, FIFO replacement on a
// fault, dirty tracking and the registered result.
// ---------------------------------------------------------------------------
module dpft_back
    import dpft_pkg::*;
#(
    parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
    parameter int VIRTUAL_PAGES    = VIRTUAL_PAGES_DEF,
    parameter int FRAMES           = FRAMES_DEF,
    localparam int PAGE_BITS       = $clog2(VIRTUAL_PAGES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic                        i_q_cmd,
    input  logic [PAGE_BITS-1:0]        i_q_page,
    input  logic [PAGE_OFFSET_BITS-1:0] i_q_off,
    output logic                        o_rsp_valid,
    output t_rsp                        o_rsp
);

    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PA_FULL_W  = FRAME_BITS + PAGE_OFFSET_BITS;

    t_back_state                 r_state, n_state;
    logic [FRAMES-1:0]           r_hit_vec;
    logic                        r_cmd;
    logic [PAGE_BITS-1:0]        r_page;
    logic [PAGE_OFFSET_BITS-1:0] r_off;

    // per-frame tables
    logic [PAGE_BITS-1:0]        r_owner [FRAMES];
    logic [FRAMES-1:0]           r_in_use;
    logic [FRAMES-1:0]           r_dirty;
    logic [FRAME_BITS-1:0]       r_ptr;

    logic                        r_rsp_valid;
    t_rsp                        r_rsp;

    logic [FRAMES-1:0]           hit_vec;
    logic                        hit;
    logic [FRAME_BITS-1:0]       hit_frame;
    logic [FRAME_BITS-1:0]       frame;
    logic [PA_FULL_W-1:0]        pa_full;
    logic                        exec;

    // owner match against the queue head, one compare per frame
    always_comb begin
        for (int f = 0; f < FRAMES; f++) begin
            hit_vec[f] = r_in_use[f] && (r_owner[f] == i_q_page);
        end
    end

    assign o_q_pop = (r_state == S_LOOK) && i_q_valid;
    assign exec    = (r_state == S_EXEC);

    // sequencer: look up in S_LOOK, then carry out in S_EXEC
    always_comb begin
        case (r_state)
            S_LOOK:  n_state = i_q_valid ? S_EXEC : S_LOOK;
            S_EXEC:  n_state = S_LOOK;
            default: n_state = S_LOOK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOOK;
        end else begin
            r_state <= n_state;
        end
    end

    // capture item and match vector
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_hit_vec <= hit_vec;
            r_cmd     <= i_q_cmd;
            r_page    <= i_q_page;
            r_off     <= i_q_off;
        end
    end

    // encode the matching frame (at most one bit set)
    always_comb begin
        hit       = |r_hit_vec;
        hit_frame = '0;
        for (int f = 0; f < FRAMES; f++) begin
            if (r_hit_vec[f]) begin
                hit_frame = hit_frame | FRAME_BITS'(f);
            end
        end
        frame   = hit ? hit_frame : r_ptr;
        pa_full = {frame, r_off};
    end

    // table update: in-use, dirty and FIFO pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_dirty  <= '0;
            r_ptr    <= '0;
        end else if (exec) begin
            if (hit) begin
                if (r_cmd == CMD_WRITE) begin
                    r_dirty[hit_frame] <= 1'b1;
                end
            end else begin
                r_in_use[r_ptr] <= 1'b1;
                r_dirty[r_ptr]  <= (r_cmd == CMD_WRITE);
                r_ptr <= (r_ptr == FRAME_BITS'(FRAMES - 1)) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    // owner table write on a fault
    always_ff @(posedge i_clk) begin
        if (exec && !hit) begin
            r_owner[r_ptr] <= r_page;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_rsp.phys_addr       <= PA_W'(pa_full);
            r_rsp.page_fault      <= !hit;
            r_rsp.evict_valid     <= !hit && r_in_use[r_ptr];
            r_rsp.evict_page      <= (!hit && r_in_use[r_ptr]) ?
                                     EV_PAGE_W'(r_owner[r_ptr]) : '0;
            r_rsp.evict_writeback <= !hit && r_in_use[r_ptr] && r_dirty[r_ptr];
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // a page lives in at most one frame
    a_single_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> $onehot0(r_hit_vec))
        else $error("page owned by more than one frame");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !r_rsp.page_fault) |-> !r_rsp.evict_valid)
        else $error("eviction reported on a hit");

    // every execute cycle is followed by a result
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_rsp_valid)
        else $error("execute cycle gave no result");

    // FIFO pointer stays within the frame range
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= FRAME_BITS'(FRAMES - 1))
        else $error("FIFO pointer beyond last frame");

endmodule

// ===== test/demand_paging_fifo_translator_unit_tb.sv =====
// ---------------------------------------------------------------------------
// demand_paging_fifo_translator_unit_tb
// Self-checking bench for the demand paging FIFO translator. A scoreboard
// keeps its own page table, frame owner table and FIFO pointer. It predicts
// each translation when the access is accepted and checks every strobed
// result field by field. Stimulus is a directed opening followed by
// working-set traffic, with varied sender gaps and a full drain between
// phases.
// ---------------------------------------------------------------------------
module demand_paging_fifo_translator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpft_pkg::*;

    localparam int OFS_W        = PAGE_OFFSET_BITS_DEF;
    localparam int VPN_W        = VA_W - OFS_W;
    localparam int N_FRAMES     = FRAMES_DEF;
    localparam int N_PAGES      = VIRTUAL_PAGES_DEF;
    localparam int N_RANDOM     = 1450;
    localparam int N_PHASES     = 4;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 150000;

    // one queued access with its sender gap rate and drain request
    typedef struct {
        t_req        req;
        int unsigned gap_pct;
        bit          drain;
    } t_access_slot;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // scoreboard copy of the translation state
    bit                    page_present [N_PAGES];
    bit                    page_dirty   [N_PAGES];
    logic [3:0]            page_slot    [N_PAGES];
    logic [VPN_W-1:0]      frame_owner  [N_FRAMES];
    bit                    frame_used   [N_FRAMES];
    logic [3:0]            fifo_ptr = '0;

    t_access_slot pending_accesses[$];
    t_rsp         expected_translations[$];

    int unsigned n_issued     = 0;
    int unsigned n_translated = 0;
    int unsigned n_faults     = 0;
    int unsigned n_evictions  = 0;
    int unsigned n_writebacks = 0;
    int unsigned n_errors     = 0;
    int unsigned cycle_cnt    = 0;

    demand_paging_fifo_translator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // translate one access and update the page and frame tables
    function automatic t_rsp predict_translation(input t_req r);
        logic [VPN_W-1:0] vpn;
        logic [VPN_W-1:0] victim;
        logic [3:0]       fr;
        t_rsp             rsp;
        vpn = r.virt_addr[VA_W-1:OFS_W];
        rsp = '0;
        if (!page_present[vpn]) begin
            fr = fifo_ptr;
            rsp.page_fault = 1'b1;
            // frame already holds a page: evict it
            if (frame_used[fr]) begin
                victim               = frame_owner[fr];
                rsp.evict_valid      = 1'b1;
                rsp.evict_page       = victim;
                rsp.evict_writeback  = page_dirty[victim];
                page_present[victim] = 1'b0;
                page_dirty[victim]   = 1'b0;
            end
            page_slot[vpn]    = fr;
            page_present[vpn] = 1'b1;
            page_dirty[vpn]   = 1'b0;
            frame_owner[fr]   = vpn;
            frame_used[fr]    = 1'b1;
            fifo_ptr          = (fr == N_FRAMES - 1) ? 4'd0 : fr + 4'd1;
        end
        if (r.cmd == CMD_WRITE) begin
            page_dirty[vpn] = 1'b1;
        end
        rsp.phys_addr = {page_slot[vpn], r.virt_addr[OFS_W-1:0]};
        return rsp;
    endfunction

    function automatic logic [VA_W-1:0] page_addr(input int unsigned vpn,
                                                  input int unsigned ofs);
        return {vpn[VPN_W-1:0], ofs[OFS_W-1:0]};
    endfunction

    function automatic void queue_access(input logic cmd, input logic [VA_W-1:0] va,
                                         input int unsigned gap_pct, input bit drain);
        t_access_slot s;
        s.req.cmd       = cmd;
        s.req.virt_addr = va;
        s.gap_pct       = gap_pct;
        s.drain         = drain;
        pending_accesses.push_back(s);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            n_errors++;
        end
    endtask

    // driver: present queued items, hold each until taken
    always @(posedge i_clk) begin
        bit fire;
        bit holding;
        bit go;
        fire    = start && !busy;
        if (fire) begin
            expected_translations.push_back(predict_translation(i_req));
            void'(pending_accesses.pop_front());
            n_issued <= n_issued + 1;
        end
        holding = start && !fire;
        go      = holding;
        if (!holding && i_rst_n && pending_accesses.size() != 0) begin
            if (pending_accesses[0].drain) begin
                go = !fire && (n_issued == n_translated);
            end else begin
                go = $urandom_range(99) >= pending_accesses[0].gap_pct;
            end
        end
        if (!i_rst_n) begin
            go = 1'b0;
        end
        start <= go;
        if (go && !holding) begin
            i_req <= pending_accesses[0].req;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (expected_translations.size() == 0) begin
                $error("unexpected result: phys_addr %0h page_fault %0b",
                       o_rsp.phys_addr, o_rsp.page_fault);
                n_errors++;
            end else begin
                want = expected_translations.pop_front();
                check_field("phys_addr", want.phys_addr, o_rsp.phys_addr);
                check_field("page_fault", want.page_fault, o_rsp.page_fault);
                check_field("evict_valid", want.evict_valid, o_rsp.evict_valid);
                check_field("evict_page", want.evict_page, o_rsp.evict_page);
                check_field("evict_writeback", want.evict_writeback,
                            o_rsp.evict_writeback);
                n_faults     += want.page_fault;
                n_evictions  += want.evict_valid;
                n_writebacks += want.evict_writeback;
                n_translated <= n_translated + 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** demand_paging_fifo_translator_unit: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned gap_of_phase  [N_PHASES] = '{0, 61, 0, 21};
        int unsigned pool_of_phase [N_PHASES] = '{12, 24, 40, 18};
        int unsigned pool[$];
        int unsigned per_phase;
        int unsigned vpn;
        logic [VA_W-1:0] va;

        // directed: free frames, hits, address extremes
        queue_access(CMD_READ,  22'h000000, 0, 1'b0);
        queue_access(CMD_WRITE, 22'h3FFFFF, 0, 1'b0);
        queue_access(CMD_READ,  22'h000ABC, 0, 1'b0);
        queue_access(CMD_WRITE, 22'h3FF123, 0, 1'b0);
        // fill the remaining frames, last one at the top of the physical space
        for (int p = 1; p <= 14; p++) begin
            queue_access(p[0], page_addr(p, (p == 14) ? 12'hFFF : p * 37), 0, 1'b0);
        end
        // faults with eviction: clean victim, dirty victim, refault of evicted page; then write hits
        queue_access(CMD_READ,  page_addr(100, 12'h5A5), 0, 1'b0);
        queue_access(CMD_READ,  page_addr(101, 12'hA5A), 0, 1'b0);
        queue_access(CMD_READ,  page_addr(1023, 12'h000), 0, 1'b0);
        queue_access(CMD_WRITE, page_addr(100, 12'hFFF), 0, 1'b0);
        queue_access(CMD_WRITE, page_addr(2, 12'h001), 0, 1'b0);

        // random: working-set traffic with some fully random addresses
        per_phase = N_RANDOM / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            pool.delete();
            for (int k = 0; k < pool_of_phase[ph]; k++) begin
                pool.push_back($urandom_range(N_PAGES - 1));
            end
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(99) < 85) begin
                    vpn = pool[$urandom_range(pool.size() - 1)];
                    va  = page_addr(vpn, $urandom_range((1 << OFS_W) - 1));
                end else begin
                    va  = VA_W'($urandom_range((1 << VA_W) - 1));
                end
                queue_access(1'($urandom_range(1)), va, gap_of_phase[ph], k == 0);
            end
        end

        // reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all items taken and all results back
        while (pending_accesses.size() != 0 || start || n_issued != n_translated) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d accesses: %0d faults, %0d evictions, %0d write-backs",
                 n_translated, n_faults, n_evictions, n_writebacks);
        $display("sender gaps of 0, 21 and 61 percent, with full drains between phases");
        if (n_errors == 0 && expected_translations.size() == 0) begin
            $display("** demand_paging_fifo_translator_unit: PASSED **");
        end else begin
            $display("** demand_paging_fifo_translator_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== demand_paging_fifo_translator_unit.f =====
design/dpft_pkg.sv
design/dpft_front.sv
design/dpft_back.sv
design/demand_paging_fifo_translator_unit.sv
test/demand_paging_fifo_translator_unit_tb.sv
